@@ hw/rtl/psq_pkg.sv @@
package psq_pkg;

    localparam int PSQ_DEPTH = 16;
    localparam int TRACK_W   = 32;
    localparam int STREAM_W  = 32;

    typedef enum logic [2:0] {
        ACT_ADD          = 3'd0,
        ACT_OK_TO_PLAY   = 3'd1,
        ACT_INV_AT       = 3'd2,
        ACT_INV_AFTER    = 3'd3,
        ACT_INV_PENDING  = 3'd4,
        ACT_INV_ALL      = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        VERDICT_NO    = 2'd0,
        VERDICT_YES   = 2'd1,
        VERDICT_LATER = 2'd2
    } t_verdict;

    typedef struct packed {
        logic [TRACK_W-1:0]  track;
        logic [STREAM_W-1:0] stream;
        logic                play_now;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [1:0]          verdict;
        logic                removed_valid;
        logic [STREAM_W-1:0] removed_stream;
        logic                add_refused;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_PLAY_CHK,
        S_AT_RD,
        S_AT_CHK,
        S_SKIP_RD,
        S_SKIP_CHK,
        S_AT_END,
        S_CMP_RD,
        S_CMP_WR,
        S_AFT_RD,
        S_AFT_CHK,
        S_RUN_RD,
        S_RUN_CHK,
        S_RUN_END,
        S_DONE
    } t_state;

endpackage

@@ hw/rtl/psq_cmd_if.sv @@
interface psq_cmd_if
    import psq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [2:0]          action;
    logic [TRACK_W-1:0]  track_id;
    logic [STREAM_W-1:0] stream_id;
    logic                play_now;

    modport source (output valid, action, track_id, stream_id, play_now, input ready);
    modport sink   (input valid, action, track_id, stream_id, play_now, output ready);
endinterface

@@ hw/rtl/psq_res_if.sv @@
interface psq_res_if
    import psq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [1:0]          verdict;
    logic                removed_valid;
    logic [STREAM_W-1:0] removed_stream;
    logic                add_refused;

    modport source (output valid, verdict, removed_valid, removed_stream, add_refused,
                    input ready);
    modport sink   (input valid, verdict, removed_valid, removed_stream, add_refused,
                    output ready);
endinterface

@@ hw/rtl/psq_ram.sv @@
module psq_ram
    import psq_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = PSQ_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/pending_stream_queue.sv @@
// Pending stream queue: a ring of up to DEPTH-1 pending streams plus one playing slot, driven
// by one command beat in and answered by exactly one result beat out. All work on the ring goes
// through a single entry RAM with one write and one registered read port, stepped by a small
// sequencer, and the block takes no new command until the current one has finished. Add,
// invalidate_pending and invalidate_all need no ring walk, ok_to_play reads the head entry
// unless the ring is empty, and invalidate_at and invalidate_after walk the ring entries they
// examine; invalidate_at also moves entries to close the gap. A result waiting in the output
// register does not block the next command, but the following result waits until it has been
// taken.
module pending_stream_queue
    import psq_pkg::*;
#(
    parameter int DEPTH = PSQ_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    psq_cmd_if.sink   i_cmd,
    psq_res_if.source o_res
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [IW:0]   DEPTH_W  = (IW + 1)'(DEPTH);
    localparam logic [IW:0]   FULL_CNT = (IW + 1)'(DEPTH - 1);

    function automatic logic [IW-1:0] next_pos(input logic [IW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    t_state              r_state, n_state;
    t_action             r_act, n_act;
    logic [TRACK_W-1:0]  r_trk, n_trk;
    logic [STREAM_W-1:0] r_sid, n_sid;
    logic                r_pn, n_pn;
    logic [IW-1:0]       r_head, n_head;
    logic [IW-1:0]       r_tail, n_tail;
    logic [IW-1:0]       r_idx, n_idx;
    logic [IW-1:0]       r_prev, n_prev;
    logic                r_move_head, n_move_head;
    logic [STREAM_W-1:0] r_last, n_last;
    t_entry              r_play, n_play;
    logic                r_play_clear, n_play_clear;
    t_result             r_res, n_res;
    t_result             r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    t_entry              ram_wdata;
    logic [IW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    t_entry              rd;

    logic                in_take;
    logic                out_take;
    logic                out_free;
    logic [IW:0]         ring_cnt;
    logic                ring_full;
    logic                idx_at_tail;
    logic                track_eq;
    logic                play_match;
    logic                run_ok;

    psq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd          = t_entry'(ram_rdata);
    assign in_take     = i_cmd.valid && i_cmd.ready;
    assign out_take    = r_out_valid && o_res.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign ring_cnt    = (r_tail >= r_head) ? ({1'b0, r_tail} - {1'b0, r_head})
                                            : ({1'b0, r_tail} + DEPTH_W - {1'b0, r_head});
    assign ring_full   = ring_cnt >= FULL_CNT;
    assign idx_at_tail = r_idx == r_tail;
    assign track_eq    = rd.track == r_trk;
    assign play_match  = r_play.track == r_trk;
    assign run_ok      = track_eq && (r_last < rd.stream) && rd.play_now;

    assign i_cmd.ready          = r_state == S_IDLE;
    assign o_res.valid          = r_out_valid;
    assign o_res.verdict        = r_out.verdict;
    assign o_res.removed_valid  = r_out.removed_valid;
    assign o_res.removed_stream = r_out.removed_stream;
    assign o_res.add_refused    = r_out.add_refused;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (r_act)
                    ACT_OK_TO_PLAY: n_state = (r_head == r_tail) ? S_DONE : S_PLAY_CHK;
                    ACT_INV_AT:     n_state = play_match ? S_SKIP_RD : S_AT_RD;
                    ACT_INV_AFTER:  n_state = play_match ? S_RUN_RD : S_AFT_RD;
                    default:        n_state = S_DONE;
                endcase
            end
            S_PLAY_CHK: n_state = S_DONE;
            S_AT_RD:    n_state = idx_at_tail ? S_DONE : S_AT_CHK;
            S_AT_CHK:   n_state = track_eq ? S_SKIP_RD : S_AT_RD;
            S_SKIP_RD:  n_state = idx_at_tail ? S_AT_END : S_SKIP_CHK;
            S_SKIP_CHK: n_state = track_eq ? S_SKIP_RD : S_AT_END;
            S_AT_END:   n_state = r_move_head ? S_DONE : S_CMP_RD;
            S_CMP_RD:   n_state = idx_at_tail ? S_DONE : S_CMP_WR;
            S_CMP_WR:   n_state = S_CMP_RD;
            S_AFT_RD:   n_state = idx_at_tail ? S_DONE : S_AFT_CHK;
            S_AFT_CHK:  n_state = track_eq ? S_RUN_RD : S_AFT_RD;
            S_RUN_RD:   n_state = idx_at_tail ? S_RUN_END : S_RUN_CHK;
            S_RUN_CHK:  n_state = run_ok ? S_RUN_RD : S_RUN_END;
            S_RUN_END:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_act        = r_act;
        n_trk        = r_trk;
        n_sid        = r_sid;
        n_pn         = r_pn;
        n_head       = r_head;
        n_tail       = r_tail;
        n_idx        = r_idx;
        n_prev       = r_prev;
        n_move_head  = r_move_head;
        n_last       = r_last;
        n_play       = r_play;
        n_play_clear = r_play_clear;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !out_take;
        ram_we       = 1'b0;
        ram_waddr    = r_prev;
        ram_wdata    = rd;
        ram_raddr    = r_idx;

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_act = t_action'(i_cmd.action);
                    n_trk = i_cmd.track_id;
                    n_sid = i_cmd.stream_id;
                    n_pn  = i_cmd.play_now;
                    n_res = '0;
                end
            end
            S_DISPATCH: begin
                n_idx       = r_head;
                n_move_head = 1'b0;
                n_last      = r_play.stream;
                ram_raddr   = r_head;
                case (r_act)
                    ACT_ADD: begin
                        if (ring_full) begin
                            n_res.add_refused = 1'b1;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_tail;
                            ram_wdata = '{track: r_trk, stream: r_sid, play_now: r_pn};
                            n_tail    = next_pos(r_tail);
                        end
                    end
                    ACT_INV_AT: begin
                        if (play_match) begin
                            n_res.removed_valid  = 1'b1;
                            n_res.removed_stream = r_play.stream;
                            n_play               = '{track: '1, stream: '1, play_now: 1'b0};
                            n_play_clear         = 1'b1;
                            n_move_head          = 1'b1;
                        end
                    end
                    ACT_INV_PENDING: begin
                        n_tail = r_head;
                    end
                    ACT_INV_ALL: begin
                        if (!r_play_clear) begin
                            n_res.removed_valid  = 1'b1;
                            n_res.removed_stream = r_play.stream;
                            n_play               = '{track: '1, stream: '1, play_now: 1'b0};
                            n_play_clear         = 1'b1;
                        end
                        n_tail = r_head;
                    end
                    default: begin
                    end
                endcase
            end
            S_PLAY_CHK: begin
                if (rd.stream == r_sid) begin
                    n_play        = rd;
                    n_play_clear  = 1'b0;
                    n_head        = next_pos(r_head);
                    n_res.verdict = rd.play_now ? VERDICT_YES : VERDICT_LATER;
                end
            end
            S_AT_CHK: begin
                n_prev = r_idx;
                n_idx  = next_pos(r_idx);
                if (track_eq && (r_idx == r_head)) begin
                    n_move_head = 1'b1;
                end
            end
            S_SKIP_CHK: begin
                if (track_eq) begin
                    n_idx = next_pos(r_idx);
                end
            end
            S_AT_END: begin
                if (r_move_head) begin
                    n_head = r_idx;
                end
            end
            S_CMP_RD: begin
                if (idx_at_tail) begin
                    n_tail = r_prev;
                end
            end
            S_CMP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_prev;
                ram_wdata = rd;
                n_prev    = next_pos(r_prev);
                n_idx     = next_pos(r_idx);
            end
            S_AFT_CHK: begin
                if (track_eq) begin
                    n_last = rd.stream;
                end
                n_idx = next_pos(r_idx);
            end
            S_RUN_CHK: begin
                if (run_ok) begin
                    n_last = rd.stream;
                    n_idx  = next_pos(r_idx);
                end
            end
            S_RUN_END: begin
                n_tail = r_idx;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_play       <= '{track: '1, stream: '1, play_now: 1'b0};
            r_play_clear <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_play       <= n_play;
            r_play_clear <= n_play_clear;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act       <= n_act;
        r_trk       <= n_trk;
        r_sid       <= n_sid;
        r_pn        <= n_pn;
        r_idx       <= n_idx;
        r_prev      <= n_prev;
        r_move_head <= n_move_head;
        r_last      <= n_last;
        r_res       <= n_res;
        r_out       <= n_out;
    end

endmodule
